[rtl/core/zcwa_pkg.sv]
// Shared types and constants for the zero-cross window averager.
package zcwa_pkg;

  typedef enum logic [1:0] {
    CFG_THREE_PHASE = 2'd0,
    CFG_VOUT_LIMIT  = 2'd1,
    CFG_OFFS_LIMIT  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  localparam logic [15:0] VOUT_LIMIT_RESET = 16'd8000;
  localparam logic [15:0] OFFS_LIMIT_RESET = 16'd4000;
  localparam int          DIV_STEPS        = 32;

  // Control from the sequencer to each serial divider.
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

[rtl/core/zcwa_divider.sv]
// Restoring serial divider, one quotient bit per cycle while step is high, 32-bit dividend.
module zcwa_divider
  import zcwa_pkg::*;
(
  input  logic        clk,
  input  div_ctrl_t   ctrl,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic [15:0] quotient
);

  logic [31:0] quo;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [16:0] shifted;
  logic [16:0] diff;

  assign shifted = {rem[15:0], quo[31]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (ctrl.step) begin
      if (!diff[16]) begin
        rem <= diff;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  // A zero divisor gives all ones naturally, matching the expected 0xFFFF.
  assign quotient = quo[15:0];

endmodule

[rtl/core/zero_cross_window_averager_unit.sv]
// Zero-cross window averager: window sums, edge counting and serial averages.
// The result becomes valid after the 32 divider steps that follow request acceptance.
// A new request is taken only once the previous result has been taken; a held-off
// result delays the next request.
// The four averages share the divide time; each window has its own serial divider.
// Reset (rst, synchronous) clears all sums, counters, held averages and
// restores the register defaults; no clearing pass is needed.
module zero_cross_window_averager_unit
  import zcwa_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int PHASE_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] vout_sample,
  input  logic [11:0] current_sample_a,
  input  logic [11:0] current_sample_b,
  input  logic [11:0] current_sample_c,
  input  logic        polarity_changed_a,
  input  logic        polarity_changed_b,
  input  logic        polarity_changed_c,
  input  logic        calibrating,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] vout_average,
  output logic        vout_updated,
  output logic [15:0] offset_a,
  output logic [15:0] offset_b,
  output logic [15:0] offset_c,
  output logic [2:0]  offsets_updated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(DIV_STEPS + 1);
  localparam logic [11:0] SMASK = 12'((33'd1 << SAMPLE_BITS) - 33'd1);

  state_t state, state_next;
  logic [CW-1:0] step_cnt;

  logic        three_phase;
  logic [15:0] vout_limit, offs_limit;

  logic [31:0] vout_sum;
  logic [15:0] vout_count, any_edge_count;
  logic [15:0] ph_edge [3];
  logic [15:0] ph_count [3];
  logic [31:0] offs_sum [3];
  logic [2:0]  last_flag;
  logic [15:0] held_vout;
  logic [15:0] held_offs [3];
  logic        vout_close;
  logic [2:0]  offs_close;

  logic [31:0] div_dd [4];
  logic [15:0] div_ds [4];
  logic [15:0] div_q  [4];
  div_ctrl_t   dctl;

  logic [11:0] cur [3];
  logic [2:0]  flag;
  logic [11:0] vmask;
  logic [11:0] cmask [3];

  // Combinational window update of the accepted request.
  logic [31:0] vs_n;
  logic [15:0] vc_n, ae_n;
  logic [15:0] pe_n [3];
  logic [15:0] pc_n [3];
  logic [31:0] os_n [3];
  logic        v_cl;
  logic [2:0]  o_cl;
  logic [1:0]  edge_add;

  assign cur[0] = current_sample_a;
  assign cur[1] = current_sample_b;
  assign cur[2] = current_sample_c;
  assign flag   = {polarity_changed_c, polarity_changed_b, polarity_changed_a};
  assign vmask  = vout_sample & SMASK;

  always_comb begin
    vs_n     = vout_sum + 32'(vmask);
    vc_n     = vout_count + 16'd1;
    edge_add = '0;
    for (int i = 0; i < 3; i++) begin
      cmask[i] = cur[i] & SMASK;
      pe_n[i]  = ph_edge[i];
      pc_n[i]  = ph_count[i];
      os_n[i]  = offs_sum[i];
      o_cl[i]  = 1'b0;
      if (i < PHASE_COUNT) begin
        pc_n[i] = ph_count[i] + 16'd1;
        if ((i == 0 || three_phase) && flag[i] && !last_flag[i]) begin
          pe_n[i]  = ph_edge[i] + 16'd1;
          edge_add = edge_add + 2'd1;
        end
        if (calibrating) begin
          os_n[i] = offs_sum[i] + 32'(cmask[i]);
          o_cl[i] = (pe_n[i] > 16'd1 && pc_n[i] > 16'd1) || (pc_n[i] > offs_limit);
        end
      end
    end
    ae_n = any_edge_count + 16'(edge_add);
    v_cl = (ae_n != 16'd0 && vc_n > 16'd1) || (vc_n > vout_limit);
  end

  always_comb begin
    state_next = state;
    dctl       = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_DIVIDE;
          dctl.load  = 1'b1;
        end
      end
      ST_DIVIDE: begin
        dctl.step = 1'b1;
        if (step_cnt == CW'(DIV_STEPS - 1)) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIVIDE) step_cnt <= step_cnt + CW'(1);
      else                    step_cnt <= '0;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      three_phase <= 1'b1;
      vout_limit  <= VOUT_LIMIT_RESET;
      offs_limit  <= OFFS_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THREE_PHASE: three_phase <= cfg_data[0];
        CFG_VOUT_LIMIT:  vout_limit  <= cfg_data;
        CFG_OFFS_LIMIT:  offs_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout_sum       <= '0;
      vout_count     <= '0;
      any_edge_count <= '0;
      last_flag      <= '0;
      held_vout      <= '0;
      vout_close     <= 1'b0;
      offs_close     <= '0;
      for (int i = 0; i < 3; i++) begin
        ph_edge[i]   <= '0;
        ph_count[i]  <= '0;
        offs_sum[i]  <= '0;
        held_offs[i] <= '0;
      end
    end else if (dctl.load) begin
      last_flag  <= flag;
      vout_close <= v_cl;
      offs_close <= o_cl;
      if (v_cl) begin
        vout_sum <= '0; vout_count <= '0; any_edge_count <= '0;
      end else begin
        vout_sum <= vs_n; vout_count <= vc_n; any_edge_count <= ae_n;
      end
      for (int i = 0; i < 3; i++) begin
        if (o_cl[i]) begin
          ph_edge[i] <= '0; ph_count[i] <= '0; offs_sum[i] <= '0;
        end else begin
          ph_edge[i] <= pe_n[i]; ph_count[i] <= pc_n[i]; offs_sum[i] <= os_n[i];
        end
      end
    end else if (state == ST_OUTPUT && out_ready) begin
      if (vout_close) held_vout <= div_q[0];
      for (int i = 0; i < 3; i++)
        if (offs_close[i]) held_offs[i] <= div_q[i+1];
    end
  end

  // The dividers load straight from the window update of the accepted request.
  assign div_dd[0] = vs_n;
  assign div_ds[0] = vc_n - 16'd1;

  for (genvar g = 0; g < 3; g++) begin : g_div_in
    assign div_dd[g+1] = os_n[g];
    assign div_ds[g+1] = pc_n[g] - 16'd1;
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    zcwa_divider u_div (
      .clk      (clk),
      .ctrl     (dctl),
      .dividend (div_dd[g]),
      .divisor  (div_ds[g]),
      .quotient (div_q[g])
    );
  end

  // A window that closed shows its fresh quotient while the result waits.
  assign vout_average    = vout_close ? div_q[0] : held_vout;
  assign vout_updated    = vout_close;
  assign offset_a        = offs_close[0] ? div_q[1] : held_offs[0];
  assign offset_b        = offs_close[1] ? div_q[2] : held_offs[1];
  assign offset_c        = offs_close[2] ? div_q[3] : held_offs[2];
  assign offsets_updated = offs_close;

`ifndef ASSERT_OFF
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready) else $error("request taken while busy");
  a_out_after_divide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DIVIDE) else $error("result skipped divide");
  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    $past(dctl.load) && vout_close |-> vout_count == 16'd0)
    else $error("closed window not cleared");
`endif

endmodule
